/* hdl/sbh_pkg.sv */
// Shared types and constants for the string bucket hash block.
package sbh_pkg;

    localparam int CHAR_W   = 7;
    localparam int RUN_W    = 17;
    localparam int BUCKET_W = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Dividend register of the remainder unit: widest case is 17b x 7b product.
    localparam int DIV_W  = 24;
    localparam int STEP_W = $clog2(DIV_W + 1);

    // Significant bits of each dividend kind (sets the step count).
    localparam int SUM_BITS   = RUN_W + 1;
    localparam int PROD_BITS  = DIV_W;
    localparam int RUN_BITS   = RUN_W;
    localparam int FIRST_BITS = CHAR_W;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE    = CFG_IDX_W'(1);

    localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = BUCKET_W'(1024);

    localparam logic [MODE_W-1:0] MODE_FIRST   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_SUM     = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_PRODUCT = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_RESTART = MODE_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_REDUCE,
        S_FINAL,
        S_FIN_WAIT,
        S_EMIT
    } t_seq_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;   // left aligned
    } t_mod_req;

    typedef struct packed {
        logic done;
    } t_mod_rsp;

    typedef struct packed {
        logic                valid;
        logic [BUCKET_W-1:0] index;
    } t_emit;

endpackage

/* hdl/string_bucket_hash.sv */
// Top level of the string bucket hash: config registers, output register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_ready     | i_char_code, i_last_char
//  result  | out       | o_out_valid / i_out_ready   | o_bucket_index
//  config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Each byte is folded in directly in modes 0 and 3; in modes 1 and 2 the folded value
// is first reduced by the one-bit-a-cycle remainder unit before the next byte is taken.
// The last byte adds a final reduction of the first byte (mode 0) or of the running value.
// o_in_ready is high only while the sequencer is idle; one byte is worked at a time.
// A result waits in the output register; a following string proceeds until its own
// result is due. Synchronous active-low reset; config writes are always taken.
module string_bucket_hash
    import sbh_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_last_char,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BUCKET_W-1:0]  o_bucket_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BUCKET_W-1:0]  i_cfg_data
);

    localparam int MOD_W = (INDEX_WIDTH < BUCKET_W) ? INDEX_WIDTH : BUCKET_W;

    logic [BUCKET_W-1:0] r_bucket_count;
    logic [MODE_W-1:0]   r_hash_mode;
    logic                r_out_valid;
    logic [BUCKET_W-1:0] r_out_index;

    t_mod_req         mod_req;
    t_mod_rsp         mod_rsp;
    logic [MOD_W-1:0] mod_rem;
    logic             out_free;
    t_emit            emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RESET;
            r_hash_mode    <= MODE_FIRST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BUCKET_COUNT) r_bucket_count <= i_cfg_data;
            if (i_cfg_index == REG_HASH_MODE)    r_hash_mode    <= i_cfg_data[MODE_W-1:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    sbh_seq #(
        .MOD_W (MOD_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_mode      (r_hash_mode),
        .i_modulus   (r_bucket_count[MOD_W-1:0]),
        .o_req       (mod_req),
        .i_rsp       (mod_rsp),
        .i_remainder (mod_rem),
        .i_out_free  (out_free),
        .o_emit      (emit)
    );

    sbh_mod_unit #(
        .MOD_W (MOD_W)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mod_req),
        .i_divisor   (r_bucket_count[MOD_W-1:0]),
        .o_rsp       (mod_rsp),
        .o_remainder (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) r_out_index <= emit.index;
    end

    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_out_index;

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input beat taken while busy");

endmodule

/* hdl/sbh_mod_unit.sv */
// Iterative restoring remainder unit, one dividend bit per cycle.
module sbh_mod_unit
    import sbh_pkg::*;
#(
    parameter int MOD_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mod_req         i_req,
    input  logic [MOD_W-1:0] i_divisor,
    output t_mod_rsp         o_rsp,
    output logic [MOD_W-1:0] o_remainder
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [MOD_W-1:0]  r_rem;
    logic [MOD_W-1:0]  r_div;

    logic [MOD_W:0]   n_trial;
    logic             n_ge;
    logic [MOD_W:0]   n_diff;
    logic [MOD_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[DIV_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
        n_rem   = n_ge ? n_diff[MOD_W-1:0] : n_trial[MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last step
            r_done <= !i_req.start && r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
        end
    end

    // a zero count reduces everything to zero
    assign o_rsp.done  = r_done;
    assign o_remainder = (r_div == '0) ? '0 : r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_div != '0) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

/* hdl/sbh_seq.sv */
// Per-byte sequencer: hash state, fold step and remainder requests.
module sbh_seq
    import sbh_pkg::*;
#(
    parameter int MOD_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [MOD_W-1:0]  i_modulus,
    output t_mod_req          o_req,
    input  t_mod_rsp          i_rsp,
    input  logic [MOD_W-1:0]  i_remainder,
    input  logic              i_out_free,
    output t_emit             o_emit
);

    t_seq_state r_state, n_state;

    logic              r_at_start, n_at_start;
    logic [RUN_W-1:0]  r_running, n_running;
    logic [CHAR_W-1:0] r_first, n_first;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic [MODE_W-1:0] r_mode;
    logic [MOD_W-1:0]  r_n;
    logic [MOD_W-1:0]  r_result, n_result;

    logic [RUN_W-1:0]  fold_v;
    logic [RUN_W:0]    fold_sum;
    logic [DIV_W-1:0]  fold_prod;
    logic              fold_reduce;

    always_comb begin
        fold_v      = r_at_start ? ((r_mode == MODE_PRODUCT) ? RUN_W'(1) : '0) : r_running;
        fold_sum    = {1'b0, fold_v} + (RUN_W + 1)'(r_char);
        fold_prod   = DIV_W'(fold_v) * DIV_W'(r_char);
        fold_reduce = (r_mode == MODE_SUM) || (r_mode == MODE_PRODUCT);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_FOLD;
            end
            S_FOLD: begin
                if (fold_reduce) n_state = S_REDUCE;
                else if (r_last) n_state = S_FINAL;
                else n_state = S_IDLE;
            end
            S_REDUCE: begin
                if (i_rsp.done) n_state = r_last ? S_FINAL : S_IDLE;
            end
            S_FINAL: n_state = S_FIN_WAIT;
            S_FIN_WAIT: begin
                if (i_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and state updates
    always_comb begin
        o_in_ready   = 1'b0;
        o_req        = '0;
        o_emit.valid = 1'b0;
        o_emit.index = BUCKET_W'(r_result);
        n_at_start   = r_at_start;
        n_running    = r_running;
        n_first      = r_first;
        n_result     = r_result;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_FOLD: begin
                n_at_start = 1'b0;
                if (r_at_start) n_first = r_char;
                unique case (r_mode)
                    MODE_SUM: begin
                        o_req.start    = 1'b1;
                        o_req.steps    = STEP_W'(SUM_BITS);
                        o_req.dividend = {fold_sum, (DIV_W - SUM_BITS)'(0)};
                    end
                    MODE_PRODUCT: begin
                        o_req.start    = 1'b1;
                        o_req.steps    = STEP_W'(PROD_BITS);
                        o_req.dividend = fold_prod;
                    end
                    MODE_RESTART: begin
                        n_running = (fold_v > RUN_W'(r_n)) ? RUN_W'(r_char)
                                                           : fold_sum[RUN_W-1:0];
                    end
                    default: n_running = fold_v;
                endcase
            end
            S_REDUCE: begin
                if (i_rsp.done) n_running = RUN_W'(i_remainder);
            end
            S_FINAL: begin
                o_req.start = 1'b1;
                if (r_mode == MODE_FIRST) begin
                    o_req.steps    = STEP_W'(FIRST_BITS);
                    o_req.dividend = {r_first, (DIV_W - FIRST_BITS)'(0)};
                end else begin
                    o_req.steps    = STEP_W'(RUN_BITS);
                    o_req.dividend = {r_running, (DIV_W - RUN_BITS)'(0)};
                end
            end
            S_FIN_WAIT: begin
                if (i_rsp.done) begin
                    n_result   = i_remainder;
                    n_at_start = 1'b1;
                end
            end
            S_EMIT: o_emit.valid = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_at_start <= 1'b1;
            r_running  <= '0;
            r_first    <= '0;
        end else begin
            r_state    <= n_state;
            r_at_start <= n_at_start;
            r_running  <= n_running;
            r_first    <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_last <= i_last_char;
            r_mode <= i_mode;
            r_n    <= i_modulus;
        end
    end

    a_ready_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_req.start)
        else $error("remainder request while accepting a beat");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> (r_state == S_REDUCE || r_state == S_FIN_WAIT))
        else $error("unexpected remainder completion");

endmodule

/* tb/tb_string_bucket_hash.sv */
// Self-checking testbench for string_bucket_hash: random strings and configs, scoreboard.
module tb_string_bucket_hash;
    import sbh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_WIDTH  = 16;
    localparam int SETTLE_CYCLES = 80;       // worst byte plus final reduction, with margin
    localparam int PHASE_ITEMS   = 235;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    class bucket_scoreboard;
        bit [BUCKET_W-1:0] bucket_count;
        bit [MODE_W-1:0]   hash_mode;
        bit [RUN_W-1:0]    running;
        bit [CHAR_W-1:0]   first_code;
        bit                at_start;
        bit [BUCKET_W-1:0] expected_index[$];
        int unsigned       mismatches;

        function new();
            bucket_count = BUCKET_COUNT_RESET;
            hash_mode    = MODE_FIRST;
            running      = '0;
            first_code   = '0;
            at_start     = 1'b1;
            mismatches   = 0;
        endfunction

        function int unsigned wrap(int unsigned v, int unsigned n);
            return (n == 0) ? 0 : v % n;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [BUCKET_W-1:0] data);
            if (idx == REG_BUCKET_COUNT)
                bucket_count = data;
            else if (idx == REG_HASH_MODE)
                hash_mode = data[MODE_W-1:0];
        endfunction

        // Fold one accepted beat into the running hash; queue the index on the last byte.
        function void fold_char(bit [CHAR_W-1:0] code, bit is_last);
            int unsigned n;
            int unsigned v;
            n = bucket_count & ((32'd1 << INDEX_WIDTH) - 1) & 32'hFFFF;
            if (at_start) begin
                first_code = code;
                running    = (hash_mode == MODE_PRODUCT) ? RUN_W'(1) : RUN_W'(0);
            end
            v = running;
            case (hash_mode)
                MODE_SUM:     v = wrap(v + code, n);
                MODE_PRODUCT: v = wrap(v * code, n);
                MODE_RESTART: v = (v > n) ? code : v + code;
                default: ;
            endcase
            running  = RUN_W'(v);
            at_start = 1'b0;
            if (is_last) begin
                at_start = 1'b1;
                if (hash_mode == MODE_FIRST)
                    expected_index.push_back(BUCKET_W'(wrap(first_code, n)));
                else
                    expected_index.push_back(BUCKET_W'(wrap(running, n)));
            end
        endfunction

        function void check_index(bit [BUCKET_W-1:0] actual);
            bit [BUCKET_W-1:0] want;
            if (expected_index.size() == 0) begin
                $error("bucket_index: unexpected beat, expected none, actual %0d", actual);
                mismatches++;
                return;
            end
            want = expected_index.pop_front();
            if (actual !== want) begin
                $error("bucket_index: expected %0d, actual %0d", want, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 i_last_char = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    logic [BUCKET_W-1:0]  o_bucket_index;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BUCKET_W-1:0]  i_cfg_data = '0;

    bucket_scoreboard sb = new();
    int unsigned send_idle = 25;   // percent of cycles the sender holds back
    int unsigned recv_idle = 47;   // percent of cycles the receiver stalls
    int unsigned items_sent = 0;

    string_bucket_hash #(.INDEX_WIDTH(INDEX_WIDTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bucket_index (o_bucket_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_index(o_bucket_index);
    end

    // All driving tasks start and end on a falling edge; send_char and write_reg leave their valid high.
    task automatic send_char(input bit [CHAR_W-1:0] code, input bit is_last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_char_code = code;
        i_last_char = is_last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.fold_char(code, is_last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [BUCKET_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_config(input bit [BUCKET_W-1:0] cnt, input bit [BUCKET_W-1:0] mode_data);
        if ($urandom_range(1)) begin
            write_reg(REG_BUCKET_COUNT, cnt);
            write_reg(REG_HASH_MODE, mode_data);
        end else begin
            write_reg(REG_HASH_MODE, mode_data);
            write_reg(REG_BUCKET_COUNT, cnt);
        end
        i_cfg_valid = 1'b0;
    endtask

    // Let every expected index arrive, then give the block time to go quiet.
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.expected_index.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic bit [CHAR_W-1:0] pick_char();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CHAR_W'($urandom_range(127));
        endcase
    endfunction

    task automatic random_config();
        bit [BUCKET_W-1:0] cnt;
        bit [BUCKET_W-1:0] mode_data;
        case ($urandom_range(9))
            0:       cnt = '0;
            1:       cnt = 16'd1;
            2:       cnt = '1;
            3, 4, 5: cnt = BUCKET_W'($urandom_range(2, 300));
            default: cnt = BUCKET_W'($urandom_range(1, 65535));
        endcase
        // upper data bits of the mode register are don't-care
        mode_data = ($urandom_range(4) == 0) ? BUCKET_W'($urandom) : BUCKET_W'($urandom_range(3));
        set_config(cnt, mode_data);
    endtask

    initial begin
        int unsigned phase_end;
        int unsigned n_strings;
        int unsigned len;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset config: first byte mod 1024; then a single-character string
        send_char(7'd65, 1'b0);
        send_char(7'd66, 1'b1);
        send_char(7'd127, 1'b1);
        drain();

        set_config(16'hFFFF, BUCKET_W'(MODE_SUM));
        send_char(7'd127, 1'b0);
        send_char(7'd0, 1'b0);           // NUL is an ordinary byte
        send_char(7'd127, 1'b0);
        send_char(7'd127, 1'b1);
        drain();

        set_config(16'd1000, 16'hFFFE);  // mode product via masked data
        send_char(7'd127, 1'b0);
        send_char(7'd127, 1'b0);
        send_char(7'd127, 1'b1);
        drain();

        set_config(16'd100, BUCKET_W'(MODE_RESTART));
        send_char(7'd60, 1'b0);
        send_char(7'd50, 1'b0);
        send_char(7'd127, 1'b0);
        send_char(7'd3, 1'b1);
        drain();

        // zero modulus, and writes to unmapped indexes
        set_config(16'd0, BUCKET_W'(MODE_SUM));
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5A5A);
        i_cfg_valid = 1'b0;
        send_char(7'd10, 1'b0);
        send_char(7'd20, 1'b1);
        drain();

        // config change part way through a string
        set_config(16'd50, BUCKET_W'(MODE_SUM));
        send_char(7'd40, 1'b0);
        send_char(7'd30, 1'b0);
        drain();
        set_config(16'd7, BUCKET_W'(MODE_PRODUCT));
        send_char(7'd3, 1'b1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 25; recv_idle = 47; end
                1: begin send_idle = 47; recv_idle = 25; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                random_config();
                n_strings = $urandom_range(4, 12);
                for (int s = 0; s < n_strings; s++) begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                    for (int b = 0; b < len; b++)
                        send_char(pick_char(), b == len - 1);
                end
                // sometimes leave a string open across the next config write
                if ($urandom_range(4) == 0) begin
                    len = $urandom_range(1, 3);
                    for (int b = 0; b < len; b++)
                        send_char(pick_char(), 1'b0);
                end
                drain();
            end
        end

        send_char(pick_char(), 1'b1);
        drain();

        if (sb.mismatches == 0 && sb.expected_index.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hdl/sbh_pkg.sv
hdl/sbh_mod_unit.sv
hdl/sbh_seq.sv
hdl/string_bucket_hash.sv
tb/tb_string_bucket_hash.sv
